@@ hdl/rth_pkg.sv @@
// Shared definitions for the RGB to HSV converter.
// Default channel and result widths used by the interfaces and the top level.
// No dependencies.
package rth_pkg;

	localparam int unsigned CHANNEL_BITS_DEF = 8;
	localparam int unsigned OUT_BITS_DEF     = 16;

	// Guard bits on the hue divisor: six times delta needs three more bits
	localparam int unsigned HUE_GUARD_BITS = 3;

endpackage

@@ hdl/rth_stream_if.sv @@
// Valid/ready stream interfaces for the RGB to HSV converter: pixel in, HSV out.
// Depends on rth_pkg for default widths.
interface rth_pix_if #(
	parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if #(
	parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
	parameter int unsigned OUT_BITS     = rth_pkg::OUT_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [OUT_BITS-1:0]     hue;
	logic [OUT_BITS-1:0]     saturation;
	logic [CHANNEL_BITS-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

@@ hdl/rth_front.sv @@
// Front stage of the converter: max, min, delta, hue numerator and divisor,
// saturation dividend. One registered stage feeding the divider chain.
// Depends on rth_pkg.
module rth_front #(
	parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
	parameter int unsigned OUT_BITS     = rth_pkg::OUT_BITS_DEF,
	parameter int unsigned HW           = CHANNEL_BITS + rth_pkg::HUE_GUARD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [HW-1:0]           hrem,
	output logic [HW-1:0]           hdiv,
	output logic [CHANNEL_BITS-1:0] srem,
	output logic [CHANNEL_BITS-1:0] sdiv,
	output logic [OUT_BITS-1:0]     sbits
);
	import rth_pkg::*;

	localparam int unsigned CB = CHANNEL_BITS;
	localparam int unsigned AW = CHANNEL_BITS + OUT_BITS;

	logic [CB-1:0] mx, mn, delta;
	logic [HW-1:0] six_d, num;
	logic [AW-1:0] sat_dvd;

	logic          valid_s1;
	logic [HW-1:0] hrem_s1, hdiv_s1;
	logic [CB-1:0] srem_s1, sdiv_s1;
	logic [OUT_BITS-1:0] sbits_s1;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		six_d = (HW'(delta) << 2) + (HW'(delta) << 1);
		// Sector follows the first channel equal to the maximum: red, green, blue
		if (mx == red) begin
			if (green >= blue)
				num = HW'(green) - HW'(blue);
			else
				num = six_d - (HW'(blue) - HW'(green));
		end else if (mx == green) begin
			num = (HW'(delta) << 1) + HW'(blue) - HW'(red);
		end else begin
			num = (HW'(delta) << 2) + HW'(red) - HW'(green);
		end
		// delta * (2^OUT_BITS - 1)
		sat_dvd = {delta, {OUT_BITS{1'b0}}} - AW'(delta);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hrem_s1  <= num;
			hdiv_s1  <= six_d;
			srem_s1  <= sat_dvd[AW-1:OUT_BITS];
			sdiv_s1  <= mx;
			sbits_s1 <= sat_dvd[OUT_BITS-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign hrem      = hrem_s1;
	assign hdiv      = hdiv_s1;
	assign srem      = srem_s1;
	assign sdiv      = sdiv_s1;
	assign sbits     = sbits_s1;

endmodule

@@ hdl/rth_div_cell.sv @@
// One cell of the divider chain: a restoring step for hue and for saturation,
// yielding one quotient bit of each per cell, with its own valid/ready stage.
// Depends on rth_pkg.
module rth_div_cell #(
	parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
	parameter int unsigned OUT_BITS     = rth_pkg::OUT_BITS_DEF,
	parameter int unsigned HW           = CHANNEL_BITS + rth_pkg::HUE_GUARD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [HW-1:0]           hrem_in,
	input  logic [HW-1:0]           hdiv_in,
	input  logic [OUT_BITS-1:0]     hq_in,
	input  logic [CHANNEL_BITS-1:0] srem_in,
	input  logic [CHANNEL_BITS-1:0] sdiv_in,
	input  logic [OUT_BITS-1:0]     sbits_in,
	input  logic [OUT_BITS-1:0]     sq_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [HW-1:0]           hrem_out,
	output logic [HW-1:0]           hdiv_out,
	output logic [OUT_BITS-1:0]     hq_out,
	output logic [CHANNEL_BITS-1:0] srem_out,
	output logic [CHANNEL_BITS-1:0] sdiv_out,
	output logic [OUT_BITS-1:0]     sbits_out,
	output logic [OUT_BITS-1:0]     sq_out
);
	import rth_pkg::*;

	localparam int unsigned CB = CHANNEL_BITS;

	logic [HW:0]   hrem2, hdiff;
	logic [CB:0]   srem2, sdiff;
	logic          hbit, sbit;
	logic [HW-1:0] hnext;
	logic [CB-1:0] snext;

	logic                valid_q;
	logic [HW-1:0]       hrem_q, hdiv_q;
	logic [OUT_BITS-1:0] hq_q, sq_q, sbits_q;
	logic [CB-1:0]       srem_q, sdiv_q;

	always_comb begin
		hrem2 = {hrem_in, 1'b0};
		hdiff = hrem2 - {1'b0, hdiv_in};
		// A zero divisor (grey or black pixel) yields zero quotient bits
		hbit  = (hdiv_in != '0) && !hdiff[HW];
		hnext = hbit ? hdiff[HW-1:0] : hrem2[HW-1:0];

		srem2 = {srem_in, sbits_in[OUT_BITS-1]};
		sdiff = srem2 - {1'b0, sdiv_in};
		sbit  = (sdiv_in != '0) && !sdiff[CB];
		snext = sbit ? sdiff[CB-1:0] : srem2[CB-1:0];
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hrem_q  <= hnext;
			hdiv_q  <= hdiv_in;
			hq_q    <= {hq_in[OUT_BITS-2:0], hbit};
			srem_q  <= snext;
			sdiv_q  <= sdiv_in;
			sbits_q <= {sbits_in[OUT_BITS-2:0], 1'b0};
			sq_q    <= {sq_in[OUT_BITS-2:0], sbit};
		end
	end

	assign out_valid = valid_q;
	assign hrem_out  = hrem_q;
	assign hdiv_out  = hdiv_q;
	assign hq_out    = hq_q;
	assign srem_out  = srem_q;
	assign sdiv_out  = sdiv_q;
	assign sbits_out = sbits_q;
	assign sq_out    = sq_q;

endmodule

@@ hdl/rgb_to_hsv_converter.sv @@
// RGB to HSV converter top level: front stage plus a chain of divider cells.
// Depends on rth_pkg, rth_stream_if, rth_front and rth_div_cell.
//
// Accepts one pixel per clock while results are taken and returns one HSV
// result per pixel, in order. It has one front stage for max, min and delta,
// then OUT_BITS divider cells, each producing one bit of hue and one bit of
// saturation. Every stage has its own valid bit and holds under back-pressure,
// so empty stages fill while the output waits and throughput stays at one pixel
// per cycle whenever the sink takes results. Brightness is the largest channel.
module rgb_to_hsv_converter #(
	parameter int unsigned CHANNEL_BITS = rth_pkg::CHANNEL_BITS_DEF,
	parameter int unsigned OUT_BITS     = rth_pkg::OUT_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rth_pix_if.sink   pix,
	rth_hsv_if.source hsv
);
	import rth_pkg::*;

	localparam int unsigned HW = CHANNEL_BITS + HUE_GUARD_BITS;
	localparam int unsigned N  = OUT_BITS;

	logic                    valid [N+1];
	logic                    ready [N+1];
	logic [HW-1:0]           hrem  [N+1];
	logic [HW-1:0]           hdiv  [N+1];
	logic [OUT_BITS-1:0]     hq    [N+1];
	logic [CHANNEL_BITS-1:0] srem  [N+1];
	logic [CHANNEL_BITS-1:0] sdiv  [N+1];
	logic [OUT_BITS-1:0]     sbits [N+1];
	logic [OUT_BITS-1:0]     sq    [N+1];

	rth_front #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.OUT_BITS    (OUT_BITS),
		.HW          (HW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.red      (pix.red),
		.green    (pix.green),
		.blue     (pix.blue),
		.out_valid(valid[0]),
		.out_ready(ready[0]),
		.hrem     (hrem[0]),
		.hdiv     (hdiv[0]),
		.srem     (srem[0]),
		.sdiv     (sdiv[0]),
		.sbits    (sbits[0])
	);

	// Quotients start empty; each cell shifts in one bit
	assign hq[0] = '0;
	assign sq[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		rth_div_cell #(
			.CHANNEL_BITS(CHANNEL_BITS),
			.OUT_BITS    (OUT_BITS),
			.HW          (HW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid[i]),
			.in_ready (ready[i]),
			.hrem_in  (hrem[i]),
			.hdiv_in  (hdiv[i]),
			.hq_in    (hq[i]),
			.srem_in  (srem[i]),
			.sdiv_in  (sdiv[i]),
			.sbits_in (sbits[i]),
			.sq_in    (sq[i]),
			.out_valid(valid[i+1]),
			.out_ready(ready[i+1]),
			.hrem_out (hrem[i+1]),
			.hdiv_out (hdiv[i+1]),
			.hq_out   (hq[i+1]),
			.srem_out (srem[i+1]),
			.sdiv_out (sdiv[i+1]),
			.sbits_out(sbits[i+1]),
			.sq_out   (sq[i+1])
		);
	end

	assign ready[N]       = hsv.ready;
	assign hsv.valid      = valid[N];
	assign hsv.hue        = hq[N];
	assign hsv.saturation = sq[N];
	assign hsv.brightness = sdiv[N];

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the RGB to HSV converter (rgb_to_hsv_converter).
// Depends on rth_pkg, rth_stream_if and the converter RTL;
// the HSV predictor and stimulus are local.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CB = rth_pkg::CHANNEL_BITS_DEF;
	localparam int unsigned OB = rth_pkg::OUT_BITS_DEF;
	localparam longint unsigned OUT_MAX = (64'd1 << OB) - 64'd1;
	localparam logic [CB-1:0] CH_MAX = '1;
	localparam int unsigned SETTLE_CYCLES = OB + 8;

	typedef struct packed {
		logic [OB-1:0] hue;
		logic [OB-1:0] saturation;
		logic [CB-1:0] brightness;
	} hsv_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rth_pix_if #(.CHANNEL_BITS(CB)) pix_ch ();
	rth_hsv_if #(.CHANNEL_BITS(CB), .OUT_BITS(OB)) hsv_ch ();

	rgb_to_hsv_converter #(
		.CHANNEL_BITS(CB),
		.OUT_BITS(OB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch.sink),
		.hsv(hsv_ch.source)
	);

	hsv_t expected_hsv[$];
	int unsigned mismatch_count = 0;
	bit no_idle = 1'b0;

	always #5 clk = ~clk;

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.red   = '0;
		pix_ch.green = '0;
		pix_ch.blue  = '0;
		hsv_ch.ready = 1'b0;
	end

	function automatic hsv_t predict_hsv(input logic [CB-1:0] r, input logic [CB-1:0] g,
		input logic [CB-1:0] b);
		longint unsigned rl;
		longint unsigned gl;
		longint unsigned bl;
		longint unsigned top;
		longint unsigned bottom;
		longint unsigned delta;
		longint unsigned six_d;
		longint unsigned num;
		longint unsigned quot;
		hsv_t res;
		rl = 64'(r);
		gl = 64'(g);
		bl = 64'(b);
		top = rl;
		bottom = rl;
		if (gl > top) top = gl;
		if (bl > top) top = bl;
		if (gl < bottom) bottom = gl;
		if (bl < bottom) bottom = bl;
		delta = top - bottom;
		res = '0;
		if (delta != 0) begin
			six_d = 6 * delta;
			// sector follows the first channel at the maximum: red, then green, then blue
			if (top == rl) begin
				num = (gl >= bl) ? (gl - bl) : (six_d - (bl - gl));
			end else if (top == gl) begin
				num = 2 * delta + bl - rl;
			end else begin
				num = 4 * delta + rl - gl;
			end
			quot = (num << OB) / six_d;
			if (quot > OUT_MAX) quot = OUT_MAX;
			res.hue = quot[OB-1:0];
		end
		if (top != 0) begin
			quot = (delta * OUT_MAX) / top;
			if (quot > OUT_MAX) quot = OUT_MAX;
			res.saturation = quot[OB-1:0];
		end
		res.brightness = top[CB-1:0];
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Called right after a rising edge; returns right after the transfer edge with valid held.
	task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
		input logic [CB-1:0] b);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.red   <= r;
		pix_ch.green <= g;
		pix_ch.blue  <= b;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		expected_hsv.push_back(predict_hsv(r, g, b));
	endtask

	// Black, white, grey, single-channel and near-extreme pixels.
	task automatic test_extremes();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(CH_MAX, CH_MAX, CH_MAX);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(CH_MAX, 8'd0, 8'd0);
		send_pixel(8'd0, CH_MAX, 8'd0);
		send_pixel(8'd0, 8'd0, CH_MAX);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(CH_MAX, CH_MAX - 1'b1, CH_MAX - 1'b1);
		send_pixel(8'd0, 8'd1, 8'd1);
	endtask

	// Two channels share the maximum.
	task automatic test_max_ties();
		send_pixel(CH_MAX, CH_MAX, 8'd0);
		send_pixel(8'd0, CH_MAX, CH_MAX);
		send_pixel(CH_MAX, 8'd0, CH_MAX);
		send_pixel(8'd200, 8'd200, 8'd10);
		send_pixel(8'd10, 8'd200, 8'd200);
		send_pixel(8'd200, 8'd10, 8'd200);
	endtask

	// Red sector with blue above green wraps by one turn; green and blue sectors either side.
	task automatic test_hue_sectors();
		send_pixel(CH_MAX, 8'd0, 8'd1);
		send_pixel(CH_MAX, 8'd10, 8'd200);
		send_pixel(CH_MAX, 8'd0, CH_MAX - 1'b1);
		send_pixel(8'd0, CH_MAX, 8'd1);
		send_pixel(CH_MAX - 1'b1, CH_MAX, 8'd0);
		send_pixel(8'd1, 8'd0, CH_MAX);
		send_pixel(8'd0, 8'd1, CH_MAX);
	endtask

	task automatic test_random_pixels(input int unsigned count);
		logic [CB-1:0] ch[3];
		int unsigned mode;
		int unsigned j;
		int unsigned k;
		int base;
		int v;
		for (int unsigned n = 0; n < count; n++) begin
			// alternate stretches with and without idling
			if (n % 250 == 0) no_idle = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 9);
			for (int c = 0; c < 3; c++) ch[c] = CB'($urandom_range(0, CH_MAX));
			case (mode)
				6: begin
					j = $urandom_range(0, 2);
					k = (j + $urandom_range(1, 2)) % 3;
					ch[k] = ch[j];
				end
				7: begin
					base = $urandom_range(0, CH_MAX);
					for (int c = 0; c < 3; c++) begin
						v = base + $urandom_range(0, 4) - 2;
						if (v < 0) v = 0;
						if (v > int'(CH_MAX)) v = int'(CH_MAX);
						ch[c] = CB'(v);
					end
				end
				8: begin
					for (int c = 0; c < 3; c++) begin
						case ($urandom_range(0, 4))
							0: ch[c] = '0;
							1: ch[c] = CB'(1);
							2: ch[c] = CH_MAX - 1'b1;
							3: ch[c] = CH_MAX;
							default: ;
						endcase
					end
				end
				9: begin
					ch[1] = ch[0];
					ch[2] = ch[0];
				end
				default: ;
			endcase
			send_pixel(ch[0], ch[1], ch[2]);
		end
		no_idle = 1'b0;
	endtask

	// Sink: random back-pressure, held off during stretches without idling.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				hsv_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				hsv_ch.ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 99) < 25) stall_left = pick_gap();
			end
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		hsv_t want;
		if (arst_n && hsv_ch.valid && hsv_ch.ready) begin
			if (expected_hsv.size() == 0) begin
				$error("unexpected result: hue %0d saturation %0d brightness %0d",
					hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
				mismatch_count++;
			end else begin
				want = expected_hsv.pop_front();
				if (hsv_ch.hue !== want.hue) begin
					$error("hue: expected %0d, actual %0d", want.hue, hsv_ch.hue);
					mismatch_count++;
				end
				if (hsv_ch.saturation !== want.saturation) begin
					$error("saturation: expected %0d, actual %0d", want.saturation,
						hsv_ch.saturation);
					mismatch_count++;
				end
				if (hsv_ch.brightness !== want.brightness) begin
					$error("brightness: expected %0d, actual %0d", want.brightness,
						hsv_ch.brightness);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_max_ties();
		test_hue_sectors();
		test_random_pixels(2000);
		pix_ch.valid <= 1'b0;
		while (expected_hsv.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
